>>> rtl/core/ttdr_pkg.sv
// -----------------------------------------------------------------------------
// ttdr_pkg
// Shared types and constants for the tick timer with drift-trimmed reload.
// -----------------------------------------------------------------------------
package ttdr_pkg;

   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
   // Reciprocal of ten: (x * RECIP_TENTH) >> TENTH_SHIFT equals x / 10 for any 32-bit x.
   localparam logic [31:0] RECIP_TENTH = 32'hCCCC_CCCD;
   localparam int          TENTH_SHIFT = 35;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_ALARM  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DRAIN,
      ST_PASS,
      ST_TRIM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;     // latch the accepted request
      logic samp_write;  // write the sample into the store
      logic fill_inc;    // advance the fill count
      logic sel_start;   // set up the first selection pass
      logic scan_step;   // read one stored sample and advance the scan
      logic pass_next;   // move on to the next selection pass
      logic rate_load;   // take the selected sample as the rate
      logic cal_finish;  // end of a calibration set
      logic failed_set;  // too few nonzero samples
      logic tick_step;   // count the tick, check the alarm, start the trim product
      logic tick_trim;   // form the trimmed reload value
      logic alarm_write; // write the alarm
      logic rsp_load;    // move the finished result into the output register
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   fill_last;
      logic   scan_last;
      logic   found;
      logic   pass_last;
   } status_type;

endpackage

>>> rtl/core/ttdr_ram.sv
// -----------------------------------------------------------------------------
// ttdr_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
module ttdr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ttdr_ctrl.sv
// -----------------------------------------------------------------------------
// ttdr_ctrl
// Controller: sequences one request at a time and hands the result to the
// output register.
// -----------------------------------------------------------------------------
module ttdr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ttdr_pkg::status_type status,
   output ttdr_pkg::cmd_type    cmd
);

   ttdr_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttdr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ttdr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ttdr_pkg::ST_DECODE;
            end
         end
         ttdr_pkg::ST_DECODE: begin
            case (status.op)
               ttdr_pkg::OP_SAMPLE: begin
                  cmd.samp_write = 1'b1;
                  if (status.fill_last) begin
                     cmd.sel_start = 1'b1;
                     state_in      = ttdr_pkg::ST_SCAN;
                  end else begin
                     cmd.fill_inc = 1'b1;
                     state_in     = ttdr_pkg::ST_FINISH;
                  end
               end
               ttdr_pkg::OP_TICK: begin
                  cmd.tick_step = 1'b1;
                  state_in      = ttdr_pkg::ST_TRIM;
               end
               ttdr_pkg::OP_ALARM: begin
                  cmd.alarm_write = 1'b1;
                  state_in        = ttdr_pkg::ST_FINISH;
               end
               default: begin
                  state_in = ttdr_pkg::ST_FINISH;
               end
            endcase
         end
         ttdr_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ttdr_pkg::ST_DRAIN;
            end
         end
         ttdr_pkg::ST_DRAIN: begin
            // The last read of the pass is compared during this cycle.
            state_in = ttdr_pkg::ST_PASS;
         end
         ttdr_pkg::ST_PASS: begin
            if (!status.found) begin
               cmd.failed_set = 1'b1;
               cmd.cal_finish = 1'b1;
               state_in       = ttdr_pkg::ST_FINISH;
            end else if (status.pass_last) begin
               cmd.rate_load  = 1'b1;
               cmd.cal_finish = 1'b1;
               state_in       = ttdr_pkg::ST_FINISH;
            end else begin
               cmd.pass_next = 1'b1;
               state_in      = ttdr_pkg::ST_SCAN;
            end
         end
         ttdr_pkg::ST_TRIM: begin
            cmd.tick_trim = 1'b1;
            state_in      = ttdr_pkg::ST_FINISH;
         end
         ttdr_pkg::ST_FINISH: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ttdr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttdr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_tready = (state_ff == ttdr_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/core/ttdr_dpath.sv
// -----------------------------------------------------------------------------
// ttdr_dpath
// Datapath: sample store, order-statistic search, tick and alarm registers,
// drift trim of the reload value and the output register.
// -----------------------------------------------------------------------------
module ttdr_dpath #(
   parameter int SAMPLE_COUNT = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ttdr_pkg::cmd_type    cmd,
   output ttdr_pkg::status_type status,
   input  logic [1:0]           req_operation,
   input  logic [31:0]          req_sample_value,
   input  logic [31:0]          req_reference_ticks,
   input  logic                 req_boot_cpu,
   input  logic [31:0]          req_alarm_value,
   output logic [31:0]          rsp_reload_value,
   output logic                 rsp_reload_valid,
   output logic                 rsp_wake,
   output logic [31:0]          rsp_tick_count_out,
   output logic                 rsp_calibration_done,
   output logic                 rsp_calibration_failed,
   output logic [31:0]          rsp_rate_out
);

   localparam int IDX_W  = $clog2(SAMPLE_COUNT);
   localparam int SKIP   = (SAMPLE_COUNT - 1) / 2;
   localparam int PASS_W = (SKIP > 0) ? $clog2(SKIP + 1) : 1;
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SAMPLE_COUNT - 1);
   localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(SKIP);

   // Captured request
   ttdr_pkg::op_type op_ff;
   logic [31:0]      sample_ff, reference_ff, alarm_req_ff;
   logic             boot_ff;

   // Architectural state
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [31:0]      rate_ff, rate_in;
   logic [31:0]      count_ff, count_in;
   logic [31:0]      alarm_ff, alarm_in;

   // Selection search
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [31:0]       prev_val_ff, prev_val_in;
   logic [IDX_W-1:0]  prev_idx_ff, prev_idx_in;
   logic              have_prev_ff, have_prev_in;
   logic [31:0]       best_val_ff, best_val_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              found_ff, found_in;
   logic [31:0]       rd_data;
   logic              above_prev, candidate;

   // Tick path and result
   logic [63:0] product_ff, product_in;
   logic [31:0] tenth;
   logic [32:0] trim_sum;
   logic [31:0] count_next;
   logic [31:0] reload_ff, reload_in;
   logic        reload_valid_ff, reload_valid_in;
   logic        wake_ff, wake_in;
   logic        done_ff, done_in;
   logic        failed_ff, failed_in;

   // Output register
   logic [31:0] out_reload_ff, out_count_ff, out_rate_ff;
   logic        out_reload_valid_ff, out_wake_ff, out_done_ff, out_failed_ff;

   ttdr_ram #(
      .WIDTH (32),
      .DEPTH (SAMPLE_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.samp_write),
      .wr_addr (fill_ff),
      .wr_data (sample_ff),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   // A sample qualifies when it follows the previous pick in (value, index)
   // order; this ranks repeated values as separate samples, lowest index first.
   assign above_prev = !have_prev_ff || (rd_data > prev_val_ff) ||
                       ((rd_data == prev_val_ff) && (rd_idx_ff > prev_idx_ff));
   assign candidate  = rd_valid_ff && (rd_data != 32'd0) && above_prev &&
                       (!found_ff || (rd_data < best_val_ff));

   assign count_next = count_ff + 32'd1;
   assign tenth      = {3'b000, product_ff[63:ttdr_pkg::TENTH_SHIFT]};
   assign trim_sum   = {1'b0, rate_ff} + {1'b0, tenth};

   always_comb begin
      fill_in         = fill_ff;
      rate_in         = rate_ff;
      count_in        = count_ff;
      alarm_in        = alarm_ff;
      scan_in         = scan_ff;
      pass_in         = pass_ff;
      rd_valid_in     = cmd.scan_step;
      rd_idx_in       = scan_ff;
      prev_val_in     = prev_val_ff;
      prev_idx_in     = prev_idx_ff;
      have_prev_in    = have_prev_ff;
      best_val_in     = best_val_ff;
      best_idx_in     = best_idx_ff;
      found_in        = found_ff;
      product_in      = product_ff;
      reload_in       = reload_ff;
      reload_valid_in = reload_valid_ff;
      wake_in         = wake_ff;
      done_in         = done_ff;
      failed_in       = failed_ff;

      if (cmd.capture) begin
         reload_in       = 32'd0;
         reload_valid_in = 1'b0;
         wake_in         = 1'b0;
         done_in         = 1'b0;
         failed_in       = 1'b0;
      end
      if (cmd.fill_inc) begin
         fill_in = fill_ff + IDX_W'(1);
      end
      if (cmd.sel_start) begin
         scan_in      = '0;
         pass_in      = '0;
         have_prev_in = 1'b0;
         found_in     = 1'b0;
      end
      if (cmd.scan_step) begin
         scan_in = scan_ff + IDX_W'(1);
      end
      if (candidate) begin
         best_val_in = rd_data;
         best_idx_in = rd_idx_ff;
         found_in    = 1'b1;
      end
      if (cmd.pass_next) begin
         prev_val_in  = best_val_ff;
         prev_idx_in  = best_idx_ff;
         have_prev_in = 1'b1;
         found_in     = 1'b0;
         scan_in      = '0;
         pass_in      = pass_ff + PASS_W'(1);
      end
      if (cmd.rate_load) begin
         rate_in = best_val_ff;
      end
      if (cmd.cal_finish) begin
         count_in = 32'd0;
         alarm_in = ttdr_pkg::ALL_ONES;
         fill_in  = '0;
         done_in  = 1'b1;
      end
      if (cmd.failed_set) begin
         failed_in = 1'b1;
      end
      if (cmd.tick_step) begin
         product_in = 64'(rate_ff) * 64'(ttdr_pkg::RECIP_TENTH);
         if (boot_ff) begin
            count_in = count_next;
            if (alarm_ff <= count_next) begin
               alarm_in = ttdr_pkg::ALL_ONES;
               wake_in  = 1'b1;
            end
         end
      end
      if (cmd.tick_trim) begin
         reload_valid_in = 1'b1;
         if (count_ff < reference_ff) begin
            reload_in = rate_ff - tenth;
         end else if (count_ff > reference_ff) begin
            reload_in = trim_sum[32] ? ttdr_pkg::ALL_ONES : trim_sum[31:0];
         end else begin
            reload_in = rate_ff;
         end
      end
      if (cmd.alarm_write) begin
         alarm_in = alarm_req_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         rate_ff     <= 32'd0;
         count_ff    <= 32'd0;
         alarm_ff    <= ttdr_pkg::ALL_ONES;
         scan_ff     <= '0;
         pass_ff     <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         rate_ff     <= rate_in;
         count_ff    <= count_in;
         alarm_ff    <= alarm_in;
         scan_ff     <= scan_in;
         pass_ff     <= pass_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= ttdr_pkg::op_type'(req_operation);
         sample_ff    <= req_sample_value;
         reference_ff <= req_reference_ticks;
         boot_ff      <= req_boot_cpu;
         alarm_req_ff <= req_alarm_value;
      end
      rd_idx_ff       <= rd_idx_in;
      prev_val_ff     <= prev_val_in;
      prev_idx_ff     <= prev_idx_in;
      have_prev_ff    <= have_prev_in;
      best_val_ff     <= best_val_in;
      best_idx_ff     <= best_idx_in;
      product_ff      <= product_in;
      reload_ff       <= reload_in;
      reload_valid_ff <= reload_valid_in;
      wake_ff         <= wake_in;
      done_ff         <= done_in;
      failed_ff       <= failed_in;
      if (cmd.rsp_load) begin
         out_reload_ff       <= reload_ff;
         out_reload_valid_ff <= reload_valid_ff;
         out_wake_ff         <= wake_ff;
         out_count_ff        <= count_ff;
         out_done_ff         <= done_ff;
         out_failed_ff       <= failed_ff;
         out_rate_ff         <= rate_ff;
      end
   end

   assign status.op        = op_ff;
   assign status.fill_last = (fill_ff == LAST_IDX);
   assign status.scan_last = (scan_ff == LAST_IDX);
   assign status.found     = found_ff;
   assign status.pass_last = (pass_ff == LAST_PASS);

   assign rsp_reload_value       = out_reload_ff;
   assign rsp_reload_valid       = out_reload_valid_ff;
   assign rsp_wake               = out_wake_ff;
   assign rsp_tick_count_out     = out_count_ff;
   assign rsp_calibration_done   = out_done_ff;
   assign rsp_calibration_failed = out_failed_ff;
   assign rsp_rate_out           = out_rate_ff;

endmodule

>>> rtl/core/tick_timer_with_drift_reload_unit.sv
// -----------------------------------------------------------------------------
// tick_timer_with_drift_reload_unit
// Tick timer with order-statistic calibration and drift-trimmed reload.
// -----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one response per
// request. A set-alarm request, an unused code or a sample that does not
// complete the set goes from decode to finish; a tick passes through the trim
// state between them. A sample that completes the set runs the rate selection:
// it walks the stored samples through the single read port of the sample RAM
// once per pass, for (SAMPLE_COUNT-1)/2+1 passes, and ends the search early
// when a pass finds no nonzero sample above the last pick. A finished response
// waits in the output register, and the next request is taken while it is
// still pending.
module tick_timer_with_drift_reload_unit #(
   parameter int SAMPLE_COUNT = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] sample_value, [63:32] reference_ticks, [95:64] alarm_value
   input  logic [95:0] req_tdata,
   // [1:0] operation, [2] boot_cpu
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] reload_value, [63:32] tick_count_out, [95:64] rate_out
   output logic [95:0] rsp_tdata,
   // [0] reload_valid, [1] wake, [2] calibration_done, [3] calibration_failed
   output logic [3:0]  rsp_tuser
);

   ttdr_pkg::cmd_type    cmd;
   ttdr_pkg::status_type status;

   ttdr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ttdr_dpath #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_operation          (req_tuser[1:0]),
      .req_sample_value       (req_tdata[31:0]),
      .req_reference_ticks    (req_tdata[63:32]),
      .req_boot_cpu           (req_tuser[2]),
      .req_alarm_value        (req_tdata[95:64]),
      .rsp_reload_value       (rsp_tdata[31:0]),
      .rsp_reload_valid       (rsp_tuser[0]),
      .rsp_wake               (rsp_tuser[1]),
      .rsp_tick_count_out     (rsp_tdata[63:32]),
      .rsp_calibration_done   (rsp_tuser[2]),
      .rsp_calibration_failed (rsp_tuser[3]),
      .rsp_rate_out           (rsp_tdata[95:64])
   );

endmodule

>>> rtl/core/ttdr_chk.sv
// -----------------------------------------------------------------------------
// ttdr_chk
// Port-level checks for the tick timer, bound to the top level.
// -----------------------------------------------------------------------------
module ttdr_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // No response may be left over from before a reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // A wake only ever comes with a tick response.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("wake without reload");

   // A failed calibration is still a completed set, and never a tick.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3]) |-> (rsp_tuser[2] && !rsp_tuser[0]))
      else $error("calibration failure flags inconsistent");

   // Completing a set restarts the tick count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tdata[63:32] == 32'd0))
      else $error("tick count not cleared by calibration");

endmodule

bind tick_timer_with_drift_reload_unit ttdr_chk u_ttdr_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/tick_timer_with_drift_reload_unit_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tick_timer_with_drift_reload_unit_tb
// Self-checking bench for the tick timer with calibration and reload trim.
// A short table of requests hits the corner cases first. A long random run
// then mixes calibration sets of varying zero density with ticks, alarm writes
// and unused codes. Every response is checked field by field against its row
// or a behavioral predictor. Both stream sides idle at random throughout.
// -----------------------------------------------------------------------------
module tick_timer_with_drift_reload_unit_tb;

   localparam int          SAMPLE_COUNT  = 10;
   localparam int          RATE_RANK     = (SAMPLE_COUNT - 1) / 2;
   localparam int          DIRECTED_ROWS = 26;
   localparam int          RANDOM_ITEMS  = 1150;
   localparam int          DRAIN_CYCLES  = 80;
   localparam int          CYCLE_LIMIT   = 500000;
   localparam logic [31:0] HIGH_SAMPLE   = 32'hF000_0000;
   localparam logic [31:0] ALL_ONES      = ttdr_pkg::ALL_ONES;

   typedef struct packed {
      ttdr_pkg::op_type op;
      logic [31:0]      sample;
      logic [31:0]      reference;
      logic             boot;
      logic [31:0]      alarm;
   } timer_request_type;

   typedef struct packed {
      logic [31:0] reload;
      logic        reload_valid;
      logic        wake;
      logic [31:0] count;
      logic        done;
      logic        failed;
      logic [31:0] rate;
   } timer_result_type;

   typedef struct packed {
      timer_request_type request;
      logic              typed;
      timer_result_type  result;
   } directed_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   // Predictor state.
   logic [31:0] cal_samples [SAMPLE_COUNT];
   int          cal_fill  = 0;
   logic [31:0] cur_rate  = '0;
   logic [31:0] cur_count = '0;
   logic [31:0] cur_alarm = ALL_ONES;
   int          zero_odds = 30;

   timer_result_type pending_results [$];
   int mismatch_count  = 0;
   int checked_count   = 0;
   int done_count      = 0;
   int failed_count    = 0;
   int wake_count      = 0;
   int saturated_count = 0;
   int stall_mode      = 0;
   int stall_phase     = 0;
   int cycle_count     = 0;

   // The count wrap from all ones to zero needs 2^32 boot ticks after a
   // calibration and is left to the predictor rather than the stimulus.
   directed_row_type directed_plan [DIRECTED_ROWS] = '{
      // Unused code right after reset: count and rate are still zero.
      '{'{ttdr_pkg::OP_NONE, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES}, 1'b1,
        '{32'd0, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0}},
      // Tick from another processor with zero rate: reload is zero but valid.
      '{'{ttdr_pkg::OP_TICK, ALL_ONES, 32'd0, 1'b0, ALL_ONES}, 1'b1,
        '{32'd0, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0}},
      // Alarm written equal to the count fires on the next boot tick only.
      '{'{ttdr_pkg::OP_ALARM, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_TICK, 32'd0, 32'd0, 1'b1, ALL_ONES}, 1'b0, '0},
      '{'{ttdr_pkg::OP_TICK, 32'd0, ALL_ONES, 1'b1, 32'd0}, 1'b0, '0},
      // Full set with repeated values and both extremes.
      '{'{ttdr_pkg::OP_SAMPLE, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, HIGH_SAMPLE, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, HIGH_SAMPLE, ALL_ONES, 1'b1, ALL_ONES}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, HIGH_SAMPLE, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, ALL_ONES, 1'b1, ALL_ONES}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, HIGH_SAMPLE, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, HIGH_SAMPLE, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd1, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      // A count ahead of the reference with a high rate saturates the reload.
      '{'{ttdr_pkg::OP_TICK, 32'd0, 32'd0, 1'b1, 32'd0}, 1'b0, '0},
      // Set with only three nonzero samples: the rate must survive.
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, ALL_ONES, 1'b1, ALL_ONES}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, ALL_ONES, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd1, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, ALL_ONES, 32'd0, 1'b0, 32'd0}, 1'b0, '0},
      '{'{ttdr_pkg::OP_SAMPLE, 32'd0, ALL_ONES, 1'b1, ALL_ONES}, 1'b1,
        '{32'd0, 1'b0, 1'b0, 32'd0, 1'b1, 1'b1, HIGH_SAMPLE}}
   };

   tick_timer_with_drift_reload_unit #(
      .SAMPLE_COUNT(SAMPLE_COUNT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Applies one request to the predictor state and returns its response.
   function automatic timer_result_type advance_timer(timer_request_type rq);
      timer_result_type res;
      logic [31:0]      tenth;
      logic [32:0]      raised;
      int               below;
      int               upto;
      bit               found;
      res = '0;
      case (rq.op)
         ttdr_pkg::OP_SAMPLE: begin
            cal_samples[cal_fill] = rq.sample;
            cal_fill++;
            if (cal_fill == SAMPLE_COUNT) begin
               res.done = 1'b1;
               found    = 1'b0;
               // A nonzero sample holds the wanted rank when the rank falls
               // between the counts of smaller and of not-larger samples.
               for (int i = 0; i < SAMPLE_COUNT; i++) begin
                  if (cal_samples[i] != 0 && !found) begin
                     below = 0;
                     upto  = 0;
                     for (int j = 0; j < SAMPLE_COUNT; j++) begin
                        if (cal_samples[j] != 0) begin
                           if (cal_samples[j] < cal_samples[i]) below++;
                           if (cal_samples[j] <= cal_samples[i]) upto++;
                        end
                     end
                     if (below <= RATE_RANK && RATE_RANK < upto) begin
                        cur_rate = cal_samples[i];
                        found    = 1'b1;
                     end
                  end
               end
               res.failed = !found;
               cur_count  = '0;
               cur_alarm  = ALL_ONES;
               cal_fill   = 0;
            end
         end
         ttdr_pkg::OP_TICK: begin
            tenth = cur_rate / 10;
            if (rq.boot) begin
               cur_count = cur_count + 32'd1;
               if (cur_alarm <= cur_count) begin
                  cur_alarm = ALL_ONES;
                  res.wake  = 1'b1;
               end
            end
            raised = {1'b0, cur_rate} + {1'b0, tenth};
            if (cur_count < rq.reference) begin
               res.reload = cur_rate - tenth;
            end else if (cur_count > rq.reference) begin
               res.reload = raised[32] ? ALL_ONES : raised[31:0];
            end else begin
               res.reload = cur_rate;
            end
            res.reload_valid = 1'b1;
         end
         ttdr_pkg::OP_ALARM: begin
            cur_alarm = rq.alarm;
         end
         default: ;
      endcase
      res.count = cur_count;
      res.rate  = cur_rate;
      return res;
   endfunction

   // Random request shaped around the predictor's count and calibration fill.
   function automatic timer_request_type next_random_request();
      timer_request_type rq;
      int                roll;
      rq.sample    = $urandom;
      rq.reference = $urandom;
      rq.boot      = 1'($urandom_range(0, 1));
      rq.alarm     = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         rq.op = ttdr_pkg::OP_SAMPLE;
      end else if (roll < 80) begin
         rq.op = ttdr_pkg::OP_TICK;
      end else if (roll < 95) begin
         rq.op = ttdr_pkg::OP_ALARM;
      end else begin
         rq.op = ttdr_pkg::OP_NONE;
      end
      roll = $urandom_range(0, 99);
      case (rq.op)
         ttdr_pkg::OP_SAMPLE: begin
            // Each set draws its own share of absent samples, so some sets
            // come up short and keep the old rate.
            if (cal_fill == 0) begin
               case ($urandom_range(0, 2))
                  0:       zero_odds = 5;
                  1:       zero_odds = 30;
                  default: zero_odds = 75;
               endcase
            end
            if (roll < zero_odds) begin
               rq.sample = '0;
            end else if (roll % 4 == 0) begin
               rq.sample = 32'd1000 + $urandom_range(0, 3);
            end else if (roll % 7 == 0) begin
               rq.sample = ($urandom_range(0, 1) == 0) ? ALL_ONES : 32'd1;
            end
         end
         ttdr_pkg::OP_TICK: begin
            rq.boot = (roll < 80);
            case ($urandom_range(0, 5))
               0:       rq.reference = cur_count;
               1:       rq.reference = cur_count + 32'd1;
               2:       rq.reference = cur_count - 32'd1;
               3:       rq.reference = '0;
               4:       rq.reference = ALL_ONES;
               default: ;
            endcase
         end
         ttdr_pkg::OP_ALARM: begin
            case ($urandom_range(0, 4))
               0:       rq.alarm = cur_count + $urandom_range(1, 3);
               1:       rq.alarm = cur_count;
               2:       rq.alarm = '0;
               3:       rq.alarm = ALL_ONES;
               default: ;
            endcase
         end
         default: ;
      endcase
      return rq;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 40) begin
         $display("response %0d: %s is %h, expected %h", checked_count, field, got, want);
      end
      mismatch_count++;
   endtask

   task automatic check_result(timer_result_type got, timer_result_type want);
      if (got.reload !== want.reload)
         report_mismatch("reload_value", got.reload, want.reload);
      if (got.reload_valid !== want.reload_valid)
         report_mismatch("reload_valid", 32'(got.reload_valid), 32'(want.reload_valid));
      if (got.wake !== want.wake)
         report_mismatch("wake", 32'(got.wake), 32'(want.wake));
      if (got.count !== want.count)
         report_mismatch("tick_count_out", got.count, want.count);
      if (got.done !== want.done)
         report_mismatch("calibration_done", 32'(got.done), 32'(want.done));
      if (got.failed !== want.failed)
         report_mismatch("calibration_failed", 32'(got.failed), 32'(want.failed));
      if (got.rate !== want.rate)
         report_mismatch("rate_out", got.rate, want.rate);
   endtask

   // Response side: a stall pattern that picks its mode at random among always ready,
   // random ready and a repeating pattern, plus the check of every accepted response.
   always @(posedge clock) begin
      timer_result_type got;
      stall_phase++;
      if (stall_phase % 150 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (stall_phase % 9 < 5);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.reload       = rsp_tdata[31:0];
         got.count        = rsp_tdata[63:32];
         got.rate         = rsp_tdata[95:64];
         got.reload_valid = rsp_tuser[0];
         got.wake         = rsp_tuser[1];
         got.done         = rsp_tuser[2];
         got.failed       = rsp_tuser[3];
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding, reload_value",
                            got.reload, 32'd0);
         end else begin
            check_result(got, pending_results.pop_front());
         end
         checked_count++;
         if (got.done) done_count++;
         if (got.failed) failed_count++;
         if (got.wake) wake_count++;
         if (got.reload_valid && got.reload == ALL_ONES) saturated_count++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run timed out after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Request side: bursts of back-to-back requests separated by idle gaps.
   initial begin
      timer_request_type rq;
      timer_result_type  want;
      int                burst_left;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < DIRECTED_ROWS + RANDOM_ITEMS; n++) begin
         rq = (n < DIRECTED_ROWS) ? directed_plan[n].request : next_random_request();
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 10);
         end
         req_tdata  <= {rq.alarm, rq.reference, rq.sample};
         req_tuser  <= {rq.boot, rq.op};
         req_tvalid <= 1'b1;
         do @(posedge clock); while (!req_tready);
         burst_left--;
         want = advance_timer(rq);
         if (n < DIRECTED_ROWS && directed_plan[n].typed) want = directed_plan[n].result;
         pending_results.push_back(want);
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d responses checked over %0d cycles with random stalls on both sides.",
               checked_count, cycle_count);
      $display("%0d calibration sets closed (%0d short of samples), %0d wakes,",
               done_count, failed_count, wake_count);
      $display("%0d saturated reloads.", saturated_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/ttdr_pkg.sv
rtl/core/ttdr_ram.sv
rtl/core/ttdr_ctrl.sv
rtl/core/ttdr_dpath.sv
rtl/core/tick_timer_with_drift_reload_unit.sv
rtl/core/ttdr_chk.sv
tb/tick_timer_with_drift_reload_unit_tb.sv
